// ===== src/cfl_pkg.sv =====
// ----------------------------------------------------------------------------
// cfl_pkg: shared types and constants for the CFL time-step reduction core
// Beat payloads, configuration register indexes and reset values, and the
// request/response bundle of the shared divide/square-root unit.
// ----------------------------------------------------------------------------
package cfl_pkg;

  // One input beat: a mesh cell, Q16.16 throughout
  typedef struct packed {
    logic        [31:0] depth;
    logic signed [31:0] discharge_x;
    logic signed [31:0] discharge_y;
    logic        [31:0] inradius;
    logic               last_cell;
  } cell_t;

  // One output beat
  typedef struct packed {
    logic        cell_dry;
    logic [31:0] min_step;
    logic [31:0] max_depth;
    logic        pass_done;
  } result_t;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_DRY_THRESHOLD = 2'd0;
  localparam cfg_index_t CFG_GRAVITY       = 2'd1;
  localparam cfg_index_t CFG_COURANT       = 2'd2;

  localparam logic [31:0] DRY_THRESHOLD_RST = 32'd65;
  localparam logic [31:0] GRAVITY_RST       = 32'd642908;
  localparam logic [31:0] COURANT_RST       = 32'd32768;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } iter_op_t;

  // Divide: operand is the 64-bit dividend, divisor is 33 bits, quotient
  // saturates at all ones. Square root: operand is the radicand, floor root.
  typedef struct packed {
    logic        start;
    iter_op_t    op;
    logic [63:0] operand;
    logic [32:0] divisor;
  } iter_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } iter_rsp_t;

endpackage

// ===== src/cfl_mul.sv =====
// ----------------------------------------------------------------------------
// cfl_mul: registered 32x32 unsigned multiplier
// The product is registered: it appears in the cycle after the operands are presented.
// ----------------------------------------------------------------------------
module cfl_mul
  import cfl_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] product
);

  logic [63:0] product_next;

  assign product_next = {32'd0, a} * {32'd0, b};

  always_ff @(posedge clk) begin
    product <= product_next;
  end

endmodule

// ===== src/cfl_iter_unit.sv =====
// ----------------------------------------------------------------------------
// cfl_iter_unit: shared radix-2 divider / radix-2 square root
// One subtractor serves both: restoring division retires one quotient bit a
// cycle, the digit-by-digit square root one root bit a cycle.
// ----------------------------------------------------------------------------
module cfl_iter_unit
  import cfl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  iter_req_t req,
  output iter_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  iter_op_t    op;
  logic [33:0] rem;
  logic [63:0] work;
  logic [31:0] root;
  logic [32:0] divisor;

  logic [35:0] cand;
  logic [35:0] sub;
  logic [36:0] diff;
  logic        take;
  logic        div_sat;

  always_comb begin
    if (op == OP_DIV) begin
      cand = {1'b0, rem, work[63]};
      sub  = {3'b000, divisor};
    end else begin
      cand = {rem, work[63:62]};
      sub  = {2'b00, root, 2'b01};
    end
    diff = {1'b0, cand} - {1'b0, sub};
    take = !diff[36];
  end

  // quotient would not fit in 32 bits
  assign div_sat = ({1'b0, req.operand[63:32]} >= req.divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= 5'd31;
        if (req.op == OP_DIV && div_sat) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op      <= req.op;
      divisor <= req.divisor;
      if (req.op == OP_DIV) begin
        rem  <= {2'b00, req.operand[63:32]};
        work <= {req.operand[31:0], 32'd0};
        root <= div_sat ? '1 : '0;
      end else begin
        rem  <= '0;
        work <= req.operand;
        root <= '0;
      end
    end else if (busy) begin
      rem  <= take ? diff[33:0] : cand[33:0];
      root <= {root[30:0], take};
      work <= (op == OP_DIV) ? {work[62:0], 1'b0} : {work[61:0], 2'b00};
    end
  end

  assign rsp.done  = done;
  assign rsp.value = root;

endmodule

// ===== src/cfl_timestep_reduction_core.sv =====
// ----------------------------------------------------------------------------
// cfl_timestep_reduction_core: CFL stable time-step reduction over mesh cells
//
// Usage:
//   cell channel   (cell_valid/cell_ready/mesh_cell): one beat per mesh cell.
//   result channel (result_valid/result_ready/result): one beat per cell,
//     carrying the dry flag, running minimum step, running maximum wet depth
//     and pass_done (echo of last_cell). After a last_cell beat the running
//     values return to full scale / zero for the next pass.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//     always ready; write only while the core is idle. Unknown index ignored.
// Sequencing:
//   Dry cell: from acceptance straight to the finish step, which loads the result.
//   Wet cell: five passes of the shared divide/square-root unit (a saturating
//   divide skips its iterations) plus the multiply, sum and finish steps;
//   ready only when idle, so the core holds one cell at a time.
// Reset: synchronous rst clears the sequencer and result valid, loads the
//   register defaults, min step to all ones and max depth to zero.
// Stall: the result register holds its beat until taken; a new cell is still
//   accepted, and its finish step waits while the old beat is pending.
// ----------------------------------------------------------------------------
module cfl_timestep_reduction_core
  import cfl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cell_valid,
  output logic       cell_ready,
  input  cell_t      mesh_cell,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL_GH,   // g*h
    S_C_GO,     // c = sqrt(g*h)
    S_C_WAIT,
    S_U_GO,     // u = |qx|/h
    S_U_WAIT,
    S_V_GO,     // v = |qy|/h
    S_V_WAIT,
    S_MUL_UU,
    S_MUL_VV,
    S_SUM,      // u^2 + v^2, saturating
    S_S_GO,     // sqrt(u^2+v^2)
    S_S_WAIT,
    S_MUL_NUM,  // cfl * inradius
    S_D_GO,     // step = num / speed
    S_D_WAIT,
    S_FINISH
  } state_t;

  state_t      state;

  // config registers
  logic [31:0] dry_threshold;
  logic [31:0] gravity;
  logic [31:0] courant_number;

  // accumulators
  logic [31:0] step_minimum;
  logic [31:0] depth_maximum;

  // per-cell working registers
  cell_t       cell_r;
  logic        dry;
  logic [31:0] c;
  logic [31:0] u;
  logic [31:0] v;
  logic [63:0] sq;
  logic [32:0] speed;
  logic [31:0] step;

  logic [31:0] mag_x;
  logic [31:0] mag_y;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [64:0] sum_wide;
  logic [31:0] vel;
  logic [31:0] min_next;
  logic [31:0] max_next;
  iter_req_t   req;
  iter_rsp_t   rsp;

  assign cell_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;

  // two's-complement magnitude; the most negative value maps to 2^31
  assign mag_x = cell_r.discharge_x[31] ? (~cell_r.discharge_x + 32'd1) : cell_r.discharge_x;
  assign mag_y = cell_r.discharge_y[31] ? (~cell_r.discharge_y + 32'd1) : cell_r.discharge_y;

  // velocity floor at one LSB
  assign vel = (rsp.value == 32'd0) ? 32'd1 : rsp.value;

  assign sum_wide = {1'b0, sq} + {1'b0, prod};

  always_comb begin
    case (state)
      S_MUL_UU: begin
        mul_a = u;
        mul_b = u;
      end
      S_MUL_VV: begin
        mul_a = v;
        mul_b = v;
      end
      S_MUL_NUM: begin
        mul_a = courant_number;
        mul_b = cell_r.inradius;
      end
      default: begin
        mul_a = gravity;
        mul_b = cell_r.depth;
      end
    endcase
  end

  cfl_mul u_mul (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .product (prod)
  );

  // operand steering into the shared unit
  always_comb begin
    req.start   = 1'b0;
    req.op      = OP_DIV;
    req.operand = prod;
    req.divisor = {1'b0, cell_r.depth};
    case (state)
      S_C_GO: begin
        req.start = 1'b1;
        req.op    = OP_SQRT;
      end
      S_U_GO: begin
        req.start   = 1'b1;
        req.operand = {16'd0, mag_x, 16'd0};
      end
      S_V_GO: begin
        req.start   = 1'b1;
        req.operand = {16'd0, mag_y, 16'd0};
      end
      S_S_GO: begin
        req.start   = 1'b1;
        req.op      = OP_SQRT;
        req.operand = sq;
      end
      S_D_GO: begin
        req.start   = 1'b1;
        req.divisor = speed;
      end
      default: ;
    endcase
  end

  cfl_iter_unit u_iter (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // running values including the current cell
  assign min_next = (!dry && step < step_minimum) ? step : step_minimum;
  assign max_next = (!dry && cell_r.depth > depth_maximum) ? cell_r.depth : depth_maximum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      result_valid   <= 1'b0;
      dry_threshold  <= DRY_THRESHOLD_RST;
      gravity        <= GRAVITY_RST;
      courant_number <= COURANT_RST;
      step_minimum   <= '1;
      depth_maximum  <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_DRY_THRESHOLD: dry_threshold  <= cfg_data;
          CFG_GRAVITY:       gravity        <= cfg_data;
          CFG_COURANT:       courant_number <= cfg_data;
          default: ;
        endcase
      end

      // the finish step reloads the beat itself when the old one is taken
      if (result_valid && result_ready && state != S_FINISH) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cell_valid) begin
            cell_r <= mesh_cell;
            dry    <= (mesh_cell.depth <= dry_threshold);
            state  <= (mesh_cell.depth <= dry_threshold) ? S_FINISH : S_MUL_GH;
          end
        end
        S_MUL_GH: state <= S_C_GO;
        S_C_GO:   state <= S_C_WAIT;
        S_C_WAIT: begin
          if (rsp.done) begin
            c     <= rsp.value;
            state <= S_U_GO;
          end
        end
        S_U_GO:   state <= S_U_WAIT;
        S_U_WAIT: begin
          if (rsp.done) begin
            u     <= vel;
            state <= S_V_GO;
          end
        end
        S_V_GO:   state <= S_V_WAIT;
        S_V_WAIT: begin
          if (rsp.done) begin
            v     <= vel;
            state <= S_MUL_UU;
          end
        end
        S_MUL_UU: state <= S_MUL_VV;
        S_MUL_VV: begin
          sq    <= prod;  // u^2
          state <= S_SUM;
        end
        S_SUM: begin
          sq    <= sum_wide[64] ? '1 : sum_wide[63:0];
          state <= S_S_GO;
        end
        S_S_GO:   state <= S_S_WAIT;
        S_S_WAIT: begin
          if (rsp.done) begin
            speed <= {1'b0, rsp.value} + {1'b0, c};
            state <= S_MUL_NUM;
          end
        end
        S_MUL_NUM: state <= S_D_GO;
        S_D_GO:    state <= S_D_WAIT;
        S_D_WAIT: begin
          if (rsp.done) begin
            step  <= rsp.value;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // wait for the result register to free up
          if (!result_valid || result_ready) begin
            result.cell_dry  <= dry;
            result.min_step  <= min_next;
            result.max_depth <= max_next;
            result.pass_done <= cell_r.last_cell;
            result_valid     <= 1'b1;
            step_minimum     <= cell_r.last_cell ? '1 : min_next;
            depth_maximum    <= cell_r.last_cell ? '0 : max_next;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/cfl_checker.sv =====
// ----------------------------------------------------------------------------
// cfl_checker: port-level checks for the CFL time-step reduction core
// Watches the top-level ports only; attached by bind below.
// ----------------------------------------------------------------------------
module cfl_checker
  import cfl_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       cell_valid,
  input logic       cell_ready,
  input logic       result_valid,
  input logic       result_ready,
  input result_t    result
);

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // no result beat right after reset
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // one cell at a time: accepting a cell closes the cell channel
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cell_valid && cell_ready |=> !cell_ready)
    else $error("cell accepted while busy");

  // a wet cell always leaves a nonzero max depth in its beat
  a_wet_depth: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.cell_dry |-> result.max_depth != 32'd0)
    else $error("wet cell with zero max depth");

endmodule

bind cfl_timestep_reduction_core cfl_checker u_cfl_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for cfl_timestep_reduction_core
// Streams mesh cells through the core in passes and checks every result
// beat against a cycle-free predictor of the CFL step reduction. Both
// channels idle and stall at random. The registers are rewritten between
// phases, including the extreme values.
// ----------------------------------------------------------------------------
module tb;
  import cfl_pkg::*;

  localparam cfg_index_t CFG_UNUSED = 2'd3;   // no register behind this index
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cell_valid = 1'b0;
  logic        cell_ready;
  cell_t       cell_beat = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result_beat;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_DRY_THRESHOLD;
  logic [31:0] cfg_data = '0;

  cfl_timestep_reduction_core dut (
    .clk          (clk),
    .rst          (rst),
    .cell_valid   (cell_valid),
    .cell_ready   (cell_ready),
    .mesh_cell    (cell_beat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_beat),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: register shadow copies and the two running accumulators
  // --------------------------------------------------------------------------
  logic [31:0] dry_limit   = DRY_THRESHOLD_RST;
  logic [31:0] gravity_q   = GRAVITY_RST;
  logic [31:0] courant_q   = COURANT_RST;
  logic [31:0] shortest_step = ALL_ONES;
  logic [31:0] deepest_wet   = '0;

  cell_t   pending_cells[$];
  result_t expected_results[$];

  int cells_accepted = 0;
  int results_seen   = 0;
  int wet_cells      = 0;
  int passes_closed  = 0;
  int cfg_writes     = 0;
  int errors         = 0;

  // Hard stop, set beyond the slowest legal run: roughly 1.2k cells, each with
  // its busy time and the longest idle gap and result stall.
  initial begin
    #20_000_000;
    $display("timeout: %0d cells accepted, %0d results waiting",
             cells_accepted, expected_results.size());
    $display("cfl_timestep_reduction_core: mismatch");
    $finish;
  end

  // Floor square root, Q32.32 radicand -> Q16.16 root (digit-by-digit)
  function automatic logic [31:0] floor_sqrt(input logic [63:0] radicand);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = radicand;
    root  = '0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem)
      probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root[31:0];
  endfunction

  // |q| / h in Q16.16, saturated at full scale and floored at one LSB.
  // Negating 0x80000000 leaves 2^31, which is the right magnitude unsigned.
  function automatic logic [63:0] cell_speed(input logic [31:0] q, input logic [31:0] h);
    logic [31:0] mag;
    logic [63:0] quot;
    mag  = q[31] ? (~q + 32'd1) : q;
    quot = {16'd0, mag, 16'd0} / {32'd0, h};
    if (quot > {32'd0, ALL_ONES})
      quot = {32'd0, ALL_ONES};
    if (quot == 0)
      quot = 64'd1;
    return quot;
  endfunction

  // Expected result beat for one cell; advances the running accumulators
  function automatic result_t predict_cell(input cell_t c);
    result_t     r;
    logic        dry;
    logic [63:0] u;
    logic [63:0] v;
    logic [64:0] sq_sum;
    logic [63:0] sq_sat;
    logic [31:0] wave;
    logic [32:0] speed;
    logic [63:0] num;
    logic [63:0] step;
    dry = !(c.depth > dry_limit);
    if (!dry) begin
      wet_cells++;
      if (c.depth > deepest_wet)
        deepest_wet = c.depth;
      wave   = floor_sqrt({32'd0, gravity_q} * {32'd0, c.depth});
      u      = cell_speed(c.discharge_x, c.depth);
      v      = cell_speed(c.discharge_y, c.depth);
      sq_sum = {1'b0, u * u} + {1'b0, v * v};
      sq_sat = sq_sum[64] ? {64{1'b1}} : sq_sum[63:0];
      speed  = {1'b0, floor_sqrt(sq_sat)} + {1'b0, wave};
      num    = {32'd0, courant_q} * {32'd0, c.inradius};
      step   = num / {31'd0, speed};
      if (step > {32'd0, ALL_ONES})
        step = {32'd0, ALL_ONES};
      if (step[31:0] < shortest_step)
        shortest_step = step[31:0];
    end
    r.cell_dry  = dry;
    r.min_step  = shortest_step;
    r.max_depth = deepest_wet;
    r.pass_done = c.last_cell;
    if (c.last_cell) begin
      passes_closed++;
      shortest_step = ALL_ONES;
      deepest_wet   = '0;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Idle/stall lengths: mostly none or short, a few long, and now and then a
  // calm stretch where no gap is inserted at all.
  // --------------------------------------------------------------------------
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // --------------------------------------------------------------------------
  // Cell driver. Predicts at the accepting edge, then either idles or puts
  // the next beat up. A beat on the bus is held until it is taken.
  // snd_drain holds the sender back until every result has come home.
  // --------------------------------------------------------------------------
  int snd_gap   = 0;
  int snd_calm  = 0;
  bit snd_drain = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else begin
      if (cell_valid && cell_ready) begin
        expected_results.push_back(predict_cell(cell_beat));
        cells_accepted++;
        snd_gap = pick_gap(snd_calm);
        if ($urandom_range(0, 63) == 0 || cells_accepted == 300)
          snd_drain = 1'b1;
      end
      if (snd_drain && expected_results.size() == 0)
        snd_drain = 1'b0;

      if (cell_valid && !cell_ready) begin
        // beat still waiting: hold valid and payload
      end else if (snd_gap > 0 || snd_drain || pending_cells.size() == 0) begin
        if (snd_gap > 0)
          snd_gap--;
        cell_valid <= 1'b0;
      end else begin
        cell_beat  <= pending_cells.pop_front();
        cell_valid <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Compares each taken beat with the oldest expectation and
  // throttles result_ready, sometimes while nothing is pending.
  // --------------------------------------------------------------------------
  int      rsp_stall = 0;
  int      rsp_calm  = 0;
  result_t want;

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("beat %0d unexpected: dry=%0b step=%h depth=%h done=%0b",
                     results_seen, result_beat.cell_dry, result_beat.min_step,
                     result_beat.max_depth, result_beat.pass_done);
        end else begin
          want = expected_results.pop_front();
          if (result_beat.cell_dry  !== want.cell_dry  ||
              result_beat.min_step  !== want.min_step  ||
              result_beat.max_depth !== want.max_depth ||
              result_beat.pass_done !== want.pass_done) begin
            errors++;
            if (errors <= 10)
              $display("beat %0d: exp %0b/%h/%h/%0b got %0b/%h/%h/%0b",
                       results_seen, want.cell_dry, want.min_step, want.max_depth,
                       want.pass_done, result_beat.cell_dry, result_beat.min_step,
                       result_beat.max_depth, result_beat.pass_done);
          end
        end
        rsp_stall = pick_gap(rsp_calm);
      end else if (rsp_stall == 0 && $urandom_range(0, 7) == 0) begin
        rsp_stall = pick_gap(rsp_calm);
      end

      if (rsp_stall > 0) begin
        rsp_stall--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic cell_t mk_cell(input logic [31:0] h, input logic [31:0] qx,
                                    input logic [31:0] qy, input logic [31:0] r,
                                    input logic last);
    cell_t c;
    c.depth       = h;
    c.discharge_x = qx;
    c.discharge_y = qy;
    c.inradius    = r;
    c.last_cell   = last;
    return c;
  endfunction

  function automatic logic [31:0] rand_discharge();
    logic [31:0] q;
    case ($urandom_range(0, 9))
      0:       q = 32'h8000_0000;
      1:       q = 32'h7FFF_FFFF;
      2:       q = '0;
      3, 4:    q = $urandom;
      default: begin
        q = $urandom_range(0, 32'h0010_0000);
        if ($urandom_range(0, 1) != 0)
          q = ~q + 32'd1;
      end
    endcase
    return q;
  endfunction

  // Random cell; depth spread over dry, near-threshold, typical and huge
  function automatic cell_t rand_cell();
    logic [31:0] h;
    logic [31:0] r;
    case ($urandom_range(0, 9))
      0:       h = dry_limit + 32'($urandom_range(0, 2)) - 32'd1;
      1:       h = $urandom;
      2:       h = $urandom_range(0, 255);
      3, 4:    h = $urandom_range(32'h0000_4000, 32'h0010_0000);
      8:       h = $urandom_range(0, 32'h0000_1000);
      9:       h = ALL_ONES - 32'($urandom_range(0, 255));
      default: h = $urandom_range(32'h0001_0000, 32'h0050_0000);
    endcase
    case ($urandom_range(0, 9))
      0:       r = '0;
      1:       r = ALL_ONES;
      2, 3:    r = $urandom;
      default: r = $urandom_range(32'h0000_1000, 32'h0040_0000);
    endcase
    return mk_cell(h, rand_discharge(), rand_discharge(), r,
                   $urandom_range(0, 9) == 0);
  endfunction

  // Wait until the sender is empty and every result has come back; sampled
  // on the falling edge so the clocked blocks have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cells.size() != 0 || cell_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // One register beat; valid is left high so writes can go back to back,
  // the caller drops it after the last one.
  task automatic cfg_write(input cfg_index_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_writes++;
    case (idx)
      CFG_DRY_THRESHOLD: dry_limit = data;
      CFG_GRAVITY:       gravity_q = data;
      CFG_COURANT:       courant_q = data;
      default:           ;  // unknown index, ignored by the core
    endcase
  endtask

  task automatic set_regs(input logic [31:0] thr, input logic [31:0] g,
                          input logic [31:0] cn);
    cfg_write(CFG_DRY_THRESHOLD, thr);
    cfg_write(CFG_GRAVITY, g);
    cfg_write(CFG_COURANT, cn);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++)
      pending_cells.push_back(rand_cell());
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed cells at the reset register values
    pending_cells.push_back(mk_cell(32'd0, 32'd0, 32'd0, 32'd0, 1'b1));           // all-dry pass
    pending_cells.push_back(mk_cell(32'd65, 32'h7FFF_FFFF, 32'h8000_0000,
                                    ALL_ONES, 1'b0));                              // at threshold
    pending_cells.push_back(mk_cell(32'd66, 32'd0, 32'd0, ALL_ONES, 1'b0));       // floored speed, step sat
    pending_cells.push_back(mk_cell(32'd66, 32'h8000_0000, 32'h8000_0001,
                                    32'h0001_0000, 1'b0));                         // speed sat, sum overflow
    pending_cells.push_back(mk_cell(ALL_ONES, 32'h7FFF_FFFF, 32'h8000_0000,
                                    ALL_ONES, 1'b0));                              // deepest cell
    pending_cells.push_back(mk_cell(32'd64, 32'd5, 32'd7, 32'd9, 1'b0));          // dry mid-pass
    pending_cells.push_back(mk_cell(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000,
                                    32'd0, 1'b1));                                 // zero inradius, last
    pending_cells.push_back(mk_cell(32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                                    32'h0005_0000, 1'b0));
    pending_cells.push_back(mk_cell(32'h0001_8000, 32'hFFFC_0000, 32'h0002_0000,
                                    32'h0000_8000, 1'b0));
    pending_cells.push_back(mk_cell(32'h000A_0000, 32'd12345, -32'sd54321,
                                    32'h0020_0000, 1'b1));
    pending_cells.push_back(mk_cell(32'd0, 32'd0, 32'd0, 32'd0, 1'b1));           // empty pass
    pending_cells.push_back(mk_cell(32'h0001_0000, ALL_ONES, 32'd1,
                                    32'h0001_0000, 1'b1));
    queue_random(8);
    wait_drained();

    // Low threshold (0 to 255), gravity and Courant at full scale
    set_regs($urandom_range(0, 255), ALL_ONES, ALL_ONES);
    queue_random(150);
    wait_drained();

    // Everything dry, zero gravity
    set_regs(ALL_ONES, 32'd0, $urandom);
    queue_random(40);
    wait_drained();

    // Zero threshold, zero gravity, zero Courant: every wet step is zero
    set_regs(32'd0, 32'd0, 32'd0);
    queue_random(150);
    wait_drained();

    // Back to defaults, plus a write to the unused index
    set_regs(DRY_THRESHOLD_RST, GRAVITY_RST, COURANT_RST);
    cfg_write(CFG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    queue_random(200);
    wait_drained();

    // Random register settings
    for (int p = 0; p < 3; p++) begin
      set_regs($urandom_range(0, 32'h0001_0000), $urandom, $urandom);
      queue_random(220);
      wait_drained();
    end

    // Tail: look for stray beats
    repeat (250) @(posedge clk);

    $display("%0d cells (%0d wet) in %0d passes, %0d register writes",
             cells_accepted, wet_cells, passes_closed, cfg_writes);
    $display("%0d result beats checked, %0d mismatches, %0d left waiting",
             results_seen, errors, expected_results.size());
    if (errors == 0 && expected_results.size() == 0) begin
      $display("cfl_timestep_reduction_core: match");
    end else begin
      $display("cfl_timestep_reduction_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cfl_pkg.sv
src/cfl_mul.sv
src/cfl_iter_unit.sv
src/cfl_timestep_reduction_core.sv
src/cfl_checker.sv
dv/tb.sv
